// ===== hw/rtl/cooperative_task_timer_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the task timer table checker.
// ----------------------------------------------------------------------------
`ifndef COOPERATIVE_TASK_TIMER_TABLE_ASSERT_SVH
`define COOPERATIVE_TASK_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CTT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CTT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants of the task timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int IDX_W      = 4;
   localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(TASK_SLOTS);

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK,
      ST_TICK_DONE,
      ST_DISP
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] start_delay;
      logic [31:0] repeat_period;
      logic [7:0]  slot_to_delete;
   } req_type;

   typedef struct packed {
      logic [1:0]       reply_kind;
      logic [IDX_W-1:0] slot_index;
      logic             success;
      logic             last_of_run;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec_add;
      logic exec_delete;
      logic tick_step;
      logic disp_step;
      logic emit_tick;
      logic emit_none;
      logic slot_next;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   out_free;
      logic   slot_last;
      logic   cur_pending;
      logic   any_pending;
      logic   last_pending;
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ctt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctt_ctrl
// Sequencer of the task timer table: decodes a transaction and walks the slots.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ctt_pkg::stat_type stat,
   output ctt_pkg::cmd_type       cmd
);
   import ctt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.op)
               OP_TICK: begin
                  state_in = ST_TICK;
               end
               OP_ADD: begin
                  if (stat.out_free) begin
                     cmd.exec_add = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               OP_DELETE: begin
                  if (stat.out_free) begin
                     cmd.exec_delete = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end
               OP_DISPATCH: begin
                  if (stat.any_pending) begin
                     state_in = ST_DISP;
                  end else if (stat.out_free) begin
                     cmd.emit_none = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_TICK: begin
            cmd.tick_step = 1'b1;
            cmd.slot_next = 1'b1;
            if (stat.slot_last) begin
               state_in = ST_TICK_DONE;
            end
         end
         ST_TICK_DONE: begin
            if (stat.out_free) begin
               cmd.emit_tick = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DISP: begin
            if (stat.cur_pending) begin
               if (stat.out_free) begin
                  cmd.disp_step = 1'b1;
                  cmd.slot_next = 1'b1;
                  if (stat.last_pending) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.slot_next = 1'b1;
               if (stat.slot_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ctt_datapath.sv =====
// ----------------------------------------------------------------------------
// ctt_datapath
// Slot table, captured request, slot counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctt_pkg::req_type  req_payload,
   input  wire ctt_pkg::cmd_type  cmd,
   output ctt_pkg::stat_type      stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ctt_pkg::rsp_type       rsp_payload
);
   import ctt_pkg::*;

   logic [TASK_SLOTS-1:0] occupied_ff;
   logic [TASK_SLOTS-1:0] pending_ff;
   logic [31:0]           delay_ff  [TASK_SLOTS];
   logic [31:0]           period_ff [TASK_SLOTS];

   op_type      op_ff;
   logic [31:0] dly_ff;
   logic [31:0] per_ff;
   logic [7:0]  del_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_write;

   logic [SLOT_W-1:0]     free_idx;
   logic                  any_free;
   logic [SLOT_W-1:0]     del_idx;
   logic                  del_ok;
   logic [TASK_SLOTS-1:0] above;
   logic [31:0]           cur_delay;
   logic [31:0]           cur_period;
   logic [31:0]           dec_delay;
   logic                  tick_live;

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!occupied_ff[i]) begin
            free_idx = SLOT_W'(i);
            any_free = 1'b1;
         end
      end
   end

   // Slots above the current one, for the end of a dispatch run.
   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         above[i] = (i > int'(slot_ff));
      end
   end

   assign del_idx    = del_ff[SLOT_W-1:0];
   assign del_ok     = (32'(del_ff) < TASK_SLOTS) && occupied_ff[del_idx];
   assign cur_delay  = delay_ff[slot_ff];
   assign cur_period = period_ff[slot_ff];
   assign dec_delay  = cur_delay - 32'd1;
   assign tick_live  = occupied_ff[slot_ff] && (cur_delay != 32'd0);

   assign rsp_write = cmd.exec_add || cmd.exec_delete || cmd.disp_step ||
                      cmd.emit_tick || cmd.emit_none;

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.last_of_run = 1'b1;
      if (cmd.exec_add) begin
         rsp_in.reply_kind = OP_ADD;
         rsp_in.slot_index = any_free ? IDX_W'(free_idx) : NONE_IDX;
         rsp_in.success    = any_free;
      end else if (cmd.exec_delete) begin
         rsp_in.reply_kind = OP_DELETE;
         rsp_in.slot_index = del_ok ? IDX_W'(del_idx) : NONE_IDX;
         rsp_in.success    = del_ok;
      end else if (cmd.disp_step) begin
         rsp_in.reply_kind  = OP_DISPATCH;
         rsp_in.slot_index  = IDX_W'(slot_ff);
         rsp_in.success     = 1'b1;
         rsp_in.last_of_run = ~|(pending_ff & above);
      end else if (cmd.emit_tick) begin
         rsp_in.reply_kind = OP_TICK;
         rsp_in.slot_index = NONE_IDX;
         rsp_in.success    = 1'b1;
      end else begin
         rsp_in.reply_kind = OP_DISPATCH;
         rsp_in.slot_index = NONE_IDX;
         rsp_in.success    = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff  <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.exec_add && any_free) begin
            occupied_ff[free_idx] <= 1'b1;
         end
         if (cmd.exec_delete && del_ok) begin
            occupied_ff[del_idx] <= 1'b0;
            pending_ff[del_idx]  <= 1'b0;
         end
         if (cmd.tick_step && tick_live && (dec_delay == 32'd0)) begin
            pending_ff[slot_ff] <= 1'b1;
         end
         if (cmd.disp_step) begin
            pending_ff[slot_ff] <= 1'b0;
            if (cur_period == 32'd0) begin
               occupied_ff[slot_ff] <= 1'b0;
            end
         end
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_payload.operation);
         dly_ff <= req_payload.start_delay;
         per_ff <= req_payload.repeat_period;
         del_ff <= req_payload.slot_to_delete;
      end
      if (cmd.capture) begin
         slot_ff <= '0;
      end else if (cmd.slot_next) begin
         slot_ff <= slot_ff + SLOT_W'(1);
      end
      if (cmd.exec_add && any_free) begin
         delay_ff[free_idx]  <= dly_ff;
         period_ff[free_idx] <= per_ff;
      end
      if (cmd.tick_step && tick_live) begin
         delay_ff[slot_ff] <= (dec_delay == 32'd0) ? cur_period : dec_delay;
      end
      if (rsp_write) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.op           = op_ff;
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign stat.slot_last    = (slot_ff == SLOT_W'(TASK_SLOTS - 1));
   assign stat.cur_pending  = pending_ff[slot_ff];
   assign stat.any_pending  = |pending_ff;
   assign stat.last_pending = ~|(pending_ff & above);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cooperative_task_timer_table.sv =====
// ----------------------------------------------------------------------------
// cooperative_task_timer_table
// Table of timed task slots: add, delete, tick and dispatch of pending slots.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  ctt_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  ctt_pkg::rsp_type
//
// One transaction is taken at a time. Add and delete go from the idle
// state through the execute state and back to idle. A tick walks every
// slot through one shared decrement and compare, one slot a cycle.
// A dispatch walks the slots up to the last pending one and emits one
// response per pending slot, or one failed response when none is pending.
// Reset is synchronous and clears the occupied and pending marks at once.
// A stalled response holds in the output register, and the walk waits only
// when it must write a new response while the register is still full.
//
`default_nettype none

module cooperative_task_timer_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ctt_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ctt_pkg::rsp_type      rsp_payload
);
   import ctt_pkg::*;

   // Commands flow from the sequencer to the table; status flows back.
   cmd_type  cmd;
   stat_type stat;

   // The sequencer owns the request handshake and the walk order.
   ctt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the slot table and the response register.
   ctt_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ctt_checker.sv =====
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks of the task timer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cooperative_task_timer_table_assert.svh"

module ctt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ctt_pkg::rsp_type rsp_payload
);
   import ctt_pkg::*;

   logic req_fire;
   logic rsp_stall;
   logic rsp_single;
   logic rsp_fail;
   logic rsp_tick;
   logic fail_idx_ok;
   logic tick_ok;

   assign req_fire    = req_valid && req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_single  = rsp_valid && (rsp_payload.reply_kind != OP_DISPATCH);
   assign rsp_fail    = rsp_valid && !rsp_payload.success;
   assign rsp_tick    = rsp_valid && (rsp_payload.reply_kind == OP_TICK);
   assign fail_idx_ok = (rsp_payload.slot_index == NONE_IDX);
   assign tick_ok     = rsp_payload.success && (rsp_payload.slot_index == NONE_IDX);

   `CTT_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "response not held")
   `CTT_ASSERT_NXT(a_one_at_a_time, req_fire, !req_ready, "second transaction taken while busy")
   `CTT_ASSERT_IMP(a_single_last, rsp_single, rsp_payload.last_of_run, "lone reply not last")
   `CTT_ASSERT_IMP(a_fail_index, rsp_fail, fail_idx_ok, "failed reply carries a slot index")
   `CTT_ASSERT_IMP(a_tick_ok, rsp_tick, tick_ok, "tick reply malformed")

endmodule

bind cooperative_task_timer_table ctt_checker u_ctt_checker (.*);

`default_nettype wire
